[hdl/tabq_pkg.sv]
// Shared types and constants for the three-axis Q30 biquad low-pass.
// No dependencies; imported by every module of the block.
package tabq_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 32;
    localparam int XQ_W     = 31;
    localparam int PROD_W   = 34;
    localparam int ACC_W    = 37;
    localparam int LANES    = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

    // 20 Hz Butterworth at 1 kHz
    localparam logic signed [COEF_W-1:0] RST_B0 = 32'sd3888751;
    localparam logic signed [COEF_W-1:0] RST_B1 = 32'sd7777502;
    localparam logic signed [COEF_W-1:0] RST_B2 = 32'sd3888751;
    localparam logic signed [COEF_W-1:0] RST_A1 = -32'sd1957103774;
    localparam logic signed [COEF_W-1:0] RST_A2 = 32'sd898916953;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coefs;

    typedef struct packed {
        logic adv;     // pipeline moves this cycle
        logic accept;  // input item taken
        logic fire;    // recursive stage holds an item and moves
    } t_lane_ctl;

endpackage

[hdl/three_axis_biquad_lowpass_q30.sv]
// Top level: three-axis direct-form-I biquad low-pass, Q30 coefficients.
// Depends on tabq_pkg, tabq_cfg, tabq_lane, tabq_out.
//
//   port group    dir   payload
//   s_axis_*      in    tdata: sample_x, sample_y, sample_z
//   m_axis_*      out   tdata: filtered_x, filtered_y, filtered_z
//   i_cfg_*       in    index 0..4: b0 b1 b2 a1 a2 (other indexes ignored)
//
// One item per cycle while s_axis_tready is high; an item passes the r_x0,
// r_p*, r_ff, r_acc and output registers. Throughput is set by the per-axis
// recursive stage: one a1 multiply and a three-term add close the loop.
// Reset loads the Butterworth coefficients and clears all filter state.
// s_axis_tready drops while the skid register holds an item; the whole
// pipeline freezes until m_axis takes a result.
module three_axis_biquad_lowpass_q30
    import tabq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [LANES*SAMPLE_W-1:0] s_axis_tdata,  // sample_x, sample_y, sample_z
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [LANES*SAMPLE_W-1:0] m_axis_tdata,  // filtered_x, filtered_y, filtered_z
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [COEF_W-1:0]         i_cfg_data
);

    t_coefs              coefs;
    t_lane_ctl           ctl;
    logic                full;
    logic                r_v1, r_v2, r_v3, r_v4;
    logic [SAMPLE_W-1:0] lane_out [LANES];

    tabq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (coefs)
    );

    assign s_axis_tready = !full;
    assign ctl.adv       = !full;
    assign ctl.accept    = s_axis_tvalid && !full;
    assign ctl.fire      = r_v3 && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (ctl.adv) begin
            r_v1 <= ctl.accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic signed [SAMPLE_W-1:0] filt;

        tabq_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_coefs    (coefs),
            .i_sample   (s_axis_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .o_filtered (filt)
        );

        assign lane_out[g] = filt;
    end

    tabq_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (r_v4 && ctl.adv),
        .i_lane   (lane_out),
        .o_full   (full),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

[hdl/tabq_cfg.sv]
// Coefficient register file with write decode.
// Depends on tabq_pkg.
module tabq_cfg
    import tabq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data,
    output t_coefs               o_coefs
);

    t_coefs r_coefs;
    t_coefs n_coefs;

    assign o_cfg_ready = 1'b1;
    assign o_coefs     = r_coefs;

    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_B0:  n_coefs.b0 = i_cfg_data;
                CFG_B1:  n_coefs.b1 = i_cfg_data;
                CFG_B2:  n_coefs.b2 = i_cfg_data;
                CFG_A1:  n_coefs.a1 = i_cfg_data;
                CFG_A2:  n_coefs.a2 = i_cfg_data;
                default: n_coefs = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= RST_B0;
            r_coefs.b1 <= RST_B1;
            r_coefs.b2 <= RST_B2;
            r_coefs.a1 <= RST_A1;
            r_coefs.a2 <= RST_A2;
        end else begin
            r_coefs <= n_coefs;
        end
    end

endmodule

[hdl/tabq_lane.sv]
// One axis biquad: feed-forward pipeline, recursive stage, round and saturate.
// Depends on tabq_pkg.
module tabq_lane
    import tabq_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_lane_ctl                  i_ctl,
    input  t_coefs                     i_coefs,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic signed [SAMPLE_W-1:0] o_filtered
);

    function automatic logic signed [PROD_W-1:0] qmul(
        input logic signed [COEF_W-1:0] c,
        input logic signed [COEF_W-1:0] v
    );
        logic signed [2*COEF_W-1:0] pr;
        pr = c * v;
        return pr[2*COEF_W-1:2*COEF_W-PROD_W];
    endfunction

    logic signed [XQ_W-1:0]   x0;
    logic signed [XQ_W-1:0]   r_xd1, r_xd2;
    logic signed [XQ_W-1:0]   r_x0, r_xa, r_xb;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2;
    logic signed [ACC_W-1:0]  r_ff;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [COEF_W-1:0] r_y1, r_y2;
    logic signed [PROD_W-1:0] r_a2term;
    logic signed [PROD_W-1:0] a1term;
    logic signed [COEF_W-1:0] a2src;
    logic signed [ACC_W:0]    rnd_sum;
    logic signed [ACC_W-SAMPLE_W+1:0] rnd;

    // Q15 -> Q30; never reaches beyond -2^30, so no clamp logic is needed
    assign x0 = {i_sample, {(XQ_W-SAMPLE_W){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xd1 <= '0;
            r_xd2 <= '0;
        end else if (i_ctl.accept) begin
            r_xd1 <= x0;
            r_xd2 <= r_xd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_x0 <= x0;
            r_xa <= r_xd1;
            r_xb <= r_xd2;
            r_p0 <= qmul(i_coefs.b0, {r_x0[XQ_W-1], r_x0});
            r_p1 <= qmul(i_coefs.b1, {r_xa[XQ_W-1], r_xa});
            r_p2 <= qmul(i_coefs.b2, {r_xb[XQ_W-1], r_xb});
            r_ff <= ACC_W'(r_p0) + ACC_W'(r_p1) + ACC_W'(r_p2);
        end
    end

    // recursive stage: one multiply plus a three-term add
    assign a1term = qmul(i_coefs.a1, r_y1);
    assign n_acc  = r_ff - ACC_W'(a1term) - ACC_W'(r_a2term);
    // a2 term tracks whatever y2 holds after this edge
    assign a2src  = i_ctl.fire ? r_y1 : r_y2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y1     <= '0;
            r_y2     <= '0;
            r_a2term <= '0;
        end else begin
            r_a2term <= qmul(i_coefs.a2, a2src);
            if (i_ctl.fire) begin
                r_y1 <= n_acc[COEF_W-1:0];
                r_y2 <= r_y1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire) begin
            r_acc <= n_acc;
        end
    end

    assign rnd_sum = (ACC_W+1)'(r_acc) + (ACC_W+1)'(1 << (SAMPLE_W-2));
    assign rnd     = rnd_sum[ACC_W:SAMPLE_W-1];

    always_comb begin
        if (rnd > (ACC_W-SAMPLE_W+2)'(32767)) begin
            o_filtered = 16'sh7FFF;
        end else if (rnd < -(ACC_W-SAMPLE_W+2)'(32768)) begin
            o_filtered = 16'sh8000;
        end else begin
            o_filtered = rnd[SAMPLE_W-1:0];
        end
    end

endmodule

[hdl/tabq_out.sv]
// Merges the three lane results into one item; output register plus skid.
// Depends on tabq_pkg.
module tabq_out
    import tabq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [SAMPLE_W-1:0]       i_lane [LANES],
    output logic                      o_full,
    output logic                      o_tvalid,
    input  logic                      i_tready,
    output logic [LANES*SAMPLE_W-1:0] o_tdata
);

    logic [LANES*SAMPLE_W-1:0] merged;
    logic [LANES*SAMPLE_W-1:0] r_out;
    logic [LANES*SAMPLE_W-1:0] r_skid;
    logic                      r_out_vld;
    logic                      r_skid_vld;
    logic                      free;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            merged[i*SAMPLE_W +: SAMPLE_W] = i_lane[i];
        end
    end

    assign free = !r_out_vld || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= i_push;
            end
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free) begin
            r_out <= r_skid_vld ? r_skid : merged;
        end else if (i_push) begin
            r_skid <= merged;
        end
    end

    assign o_full   = r_skid_vld;
    assign o_tvalid = r_out_vld;
    assign o_tdata  = r_out;

endmodule

[tb/biquad_checker.sv]
// Checker for the three-axis Q30 biquad low-pass: tracks coefficient writes,
// predicts each filtered item from the accepted samples and compares in order.
// Depends on tabq_pkg only.
module biquad_checker
    import tabq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [LANES*SAMPLE_W-1:0] i_in_data,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [LANES*SAMPLE_W-1:0] i_out_data,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [COEF_W-1:0]         i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_coefs                   coefs;
    logic signed [XQ_W-1:0]   x_d1 [LANES];
    logic signed [XQ_W-1:0]   x_d2 [LANES];
    logic signed [COEF_W-1:0] y_d1 [LANES];
    logic signed [COEF_W-1:0] y_d2 [LANES];
    logic [LANES*SAMPLE_W-1:0] filtered_q [$];
    string axis_name [LANES] = '{"x", "y", "z"};

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void note_fail(string msg);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    // Q30 product, floor of c*v / 2^30
    function automatic longint q30_mul(longint c, longint v);
        return (c * v) >>> 30;
    endfunction

    // advances the filter state of all three axes by one sample
    function automatic logic [LANES*SAMPLE_W-1:0] filter_sample(
        logic [LANES*SAMPLE_W-1:0] samples
    );
        logic [LANES*SAMPLE_W-1:0] filtered;
        longint x0, acc, rounded;
        for (int lane = 0; lane < LANES; lane++) begin
            x0 = longint'($signed(samples[lane*SAMPLE_W +: SAMPLE_W])) * 32768;
            if (x0 < -(64'sd1 <<< 30)) x0 = -(64'sd1 <<< 30);
            if (x0 > (64'sd1 <<< 30)) x0 = 64'sd1 <<< 30;
            acc = q30_mul(longint'($signed(coefs.b0)), x0)
                + q30_mul(longint'($signed(coefs.b1)), longint'(x_d1[lane]))
                + q30_mul(longint'($signed(coefs.b2)), longint'(x_d2[lane]))
                - q30_mul(longint'($signed(coefs.a1)), longint'(y_d1[lane]))
                - q30_mul(longint'($signed(coefs.a2)), longint'(y_d2[lane]));
            rounded = (acc + 16384) >>> 15;
            if (rounded > 32767) rounded = 32767;
            if (rounded < -32768) rounded = -32768;
            filtered[lane*SAMPLE_W +: SAMPLE_W] = rounded[SAMPLE_W-1:0];
            x_d2[lane] = x_d1[lane];
            x_d1[lane] = x0[XQ_W-1:0];
            y_d2[lane] = y_d1[lane];
            y_d1[lane] = acc[COEF_W-1:0];
        end
        return filtered;
    endfunction

    always @(posedge i_clk) begin
        logic [LANES*SAMPLE_W-1:0] want;
        logic [SAMPLE_W-1:0]       got_f, want_f;
        if (!i_rst_n) begin
            coefs = '{b0: RST_B0, b1: RST_B1, b2: RST_B2, a1: RST_A1, a2: RST_A2};
            foreach (x_d1[k]) begin
                x_d1[k] = '0;
                x_d2[k] = '0;
                y_d1[k] = '0;
                y_d2[k] = '0;
            end
            filtered_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_B0: coefs.b0 = i_cfg_data;
                    CFG_B1: coefs.b1 = i_cfg_data;
                    CFG_B2: coefs.b2 = i_cfg_data;
                    CFG_A1: coefs.a1 = i_cfg_data;
                    CFG_A2: coefs.a2 = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    note_fail($sformatf("unexpected item %h", i_out_data));
                end else begin
                    want = filtered_q.pop_front();
                    for (int lane = 0; lane < LANES; lane++) begin
                        got_f  = i_out_data[lane*SAMPLE_W +: SAMPLE_W];
                        want_f = want[lane*SAMPLE_W +: SAMPLE_W];
                        if (got_f !== want_f) begin
                            note_fail($sformatf("filtered_%s expected %0d got %0d",
                                axis_name[lane], $signed(want_f), $signed(got_f)));
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                filtered_q.push_back(filter_sample(i_in_data));
            end
        end
        o_pending = filtered_q.size();
    end

endmodule

[tb/tb_top.sv]
// Top of the biquad low-pass testbench: clock, reset, sample and coefficient
// stimulus, random back-pressure and the verdict. Depends on tabq_pkg,
// biquad_checker and the three_axis_biquad_lowpass_q30 RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tabq_pkg::*;

    localparam int PHASE_ITEMS  = 147;
    localparam int PHASES       = 7;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 100000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [LANES*SAMPLE_W-1:0] s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [LANES*SAMPLE_W-1:0] m_axis_tdata;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [COEF_W-1:0]         i_cfg_data = '0;

    int          fail_count;
    int          pending;
    bit          steady = 1'b0;
    int unsigned cycles = 0;

    three_axis_biquad_lowpass_q30 i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    biquad_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 14);
    end

    function automatic logic [LANES*SAMPLE_W-1:0] pack_axes(
        logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y, logic [SAMPLE_W-1:0] z
    );
        return {z, y, x};
    endfunction

    // half random, with full-scale hits and slow drifts around the last value
    function automatic logic [SAMPLE_W-1:0] pick_axis(logic [SAMPLE_W-1:0] prev);
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return prev + 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [LANES*SAMPLE_W-1:0] samples);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= samples;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] index,
                              input logic [COEF_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [COEF_W-1:0]         coefs [5];
        logic [COEF_W-1:0]         word;
        logic [LANES*SAMPLE_W-1:0] samples;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients, full-scale steps and clamp corner
        send_sample(pack_axes(16'h0000, 16'h0000, 16'h0000));
        send_sample(pack_axes(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_sample(pack_axes(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_sample(pack_axes(16'h8000, 16'h8000, 16'h8000));
        send_sample(pack_axes(16'h8000, 16'h8000, 16'h8000));
        send_sample(pack_axes(16'h8000, 16'h7FFF, 16'h0000));
        send_sample(pack_axes(16'h7FFF, 16'h8000, 16'hFFFF));
        send_sample(pack_axes(16'h0001, 16'hFFFF, 16'h8000));
        send_sample(pack_axes(16'hFFFF, 16'h0001, 16'h7FFF));
        send_sample(pack_axes(16'h5555, 16'hAAAA, 16'h5555));
        send_sample(pack_axes(16'hAAAA, 16'h5555, 16'hAAAA));
        send_sample(pack_axes(16'h8000, 16'h8000, 16'h7FFF));
        send_sample(pack_axes(16'h7FFF, 16'h7FFF, 16'h8000));
        send_sample(pack_axes(16'h8000, 16'h7FFF, 16'h8000));
        send_sample(pack_axes(16'h7FFF, 16'h8000, 16'h7FFF));
        send_sample(pack_axes(16'h0000, 16'h0000, 16'h0000));
        send_sample(pack_axes(16'h4000, 16'hC000, 16'h0100));
        send_sample(pack_axes(16'h8001, 16'h7FFE, 16'h00FF));
        send_sample(pack_axes(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_sample(pack_axes(16'h0000, 16'h0000, 16'h0000));

        // extremes first (saturation and feedback wrap), then assorted sets
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            for (int r = 0; r < 5; r++) begin
                word = $urandom;
                case (phase)
                    0: coefs[r] = 32'h7FFF_FFFF;
                    1: coefs[r] = 32'h8000_0000;
                    2: coefs[r] = '0;
                    3: coefs[r] = word;
                    4: coefs[r] = (r == 0) ? 32'h4000_0000 : 32'h0000_0000;
                    5: coefs[r] = '0;
                    default: coefs[r] = {{4{word[27]}}, word[27:0]};
                endcase
            end
            if (phase == 5) begin
                coefs = '{RST_B0, RST_B1, RST_B2, RST_A1, RST_A2};
            end
            if (phase % 2 == 1) begin
                write_coef(CFG_IDX_W'(CFG_A2 + 1 + $urandom_range(0, 2)), $urandom);
            end
            write_coef(CFG_B0, coefs[0]);
            write_coef(CFG_B1, coefs[1]);
            write_coef(CFG_B2, coefs[2]);
            write_coef(CFG_A1, coefs[3]);
            write_coef(CFG_A2, coefs[4]);
            if (phase % 2 == 0) begin
                write_coef(CFG_IDX_W'(CFG_A2 + 1 + $urandom_range(0, 2)), $urandom);
            end
            steady = (phase == 5);
            samples = '0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                for (int lane = 0; lane < LANES; lane++) begin
                    samples[lane*SAMPLE_W +: SAMPLE_W] =
                        pick_axis(samples[lane*SAMPLE_W +: SAMPLE_W]);
                end
                send_sample(samples);
            end
            steady = 1'b0;
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
